// ===== src/qmv_pkg.sv =====
// qmv_pkg: shared constants, types and codes for the quantized
// matrix-vector multiply block. No dependencies.
package qmv_pkg;

    localparam int VEC_LEN     = 64;
    localparam int ROWS        = 64;
    localparam int STORE_DEPTH = 64;

    localparam int COL_W     = 6;
    localparam int CODE_W    = 7;
    localparam int ACT_W     = 8;
    localparam int ZP_W      = 8;
    localparam int DIFF_W    = 9;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = 16;
    localparam int ROW_IDX_W = 6;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACT_ZP    = 1'b0;
    localparam logic REG_WEIGHT_ZP = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_MAC_LAST
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [COL_W-1:0]  column;
        logic [CODE_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]    row_index;
        logic signed [SUM_W-1:0] dot_sum;
    } res_t;

endpackage

// ===== src/qmv_front.sv =====
// qmv_front: takes input items, classifies them into load / MAC / row-closing
// MAC commands, drops out-of-range columns, and queues them for the back end.
// Depends on qmv_pkg.
module qmv_front
    import qmv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              cmd,
    input  logic [COL_W-1:0]  column,
    input  logic [CODE_W-1:0] code,
    output logic              full,
    output logic              cmd_valid,
    output cmd_t              cmd_head,
    input  logic              cmd_take
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  accept;
    logic                  col_ok;
    logic                  enq;
    cmd_t                  cls;

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign col_ok    = (32'(column) < VEC_LEN);
    assign enq       = accept && col_ok;

    always_comb
    begin
        cls.column = column;
        cls.code   = code;
        if (!cmd)
        begin
            cls.op = OP_LOAD;
        end
        else if (32'(column) == VEC_LEN - 1)
        begin
            cls.op = OP_MAC_LAST;
        end
        else
        begin
            cls.op = OP_MAC;
        end
    end

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CMDQ_CNT_W'(enq) - CMDQ_CNT_W'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== src/qmv_back.sv =====
// qmv_back: activation store and three-stage multiply-accumulate pipeline.
// Issues a command only when the result queue has room for it.
// Depends on qmv_pkg.
module qmv_back
    import qmv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd_head,
    output logic                  cmd_take,
    input  logic [ZP_W-1:0]       act_zp,
    input  logic [ZP_W-1:0]       wgt_zp,
    input  logic [OUTQ_CNT_W-1:0] outq_count,
    output logic                  res_push,
    output res_t                  res
);

    logic [ACT_W-1:0] store_mem [STORE_DEPTH];

    // stage 1: store read, weight offset applied
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic [ACT_W-1:0]         s1_act_reg;
    logic signed [DIFF_W-1:0] s1_wdiff_reg;
    // stage 2: product
    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    // stage 3: accumulator and row counter
    logic [SUM_W-1:0]         acc_reg, acc_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [SUM_W-1:0]         acc_sum;

    logic                     is_mac;
    logic [OUTQ_CNT_W+1:0]    pending;
    logic signed [DIFF_W-1:0] wdiff;
    logic signed [DIFF_W-1:0] adiff;

    // results in the queue plus those owed to it by row-closing items still in the pipe
    assign pending  = (OUTQ_CNT_W+2)'(outq_count)
                    + (OUTQ_CNT_W+2)'(s1_valid_reg && s1_last_reg)
                    + (OUTQ_CNT_W+2)'(s2_valid_reg && s2_last_reg);
    assign cmd_take = cmd_valid && (pending < (OUTQ_CNT_W+2)'(OUTQ_DEPTH));
    assign is_mac   = (cmd_head.op == OP_MAC) || (cmd_head.op == OP_MAC_LAST);

    assign wdiff = $signed({2'b00, cmd_head.code}) - $signed({wgt_zp[ZP_W-1], wgt_zp});
    assign adiff = $signed({1'b0, s1_act_reg}) - $signed({act_zp[ZP_W-1], act_zp});

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_head.op == OP_LOAD)
        begin
            store_mem[cmd_head.column] <= ACT_W'(cmd_head.code);
        end
        if (cmd_take && is_mac)
        begin
            s1_act_reg   <= store_mem[cmd_head.column];
            s1_wdiff_reg <= wdiff;
        end
        s2_prod_reg <= adiff * s1_wdiff_reg;
    end

    assign acc_sum = acc_reg + s2_prod_reg[SUM_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        row_next = row_reg;
        res_push = 1'b0;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                res_push = 1'b1;
                acc_next = '0;
                if (32'(row_reg) >= ROWS - 1)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    assign res.row_index = ROW_IDX_W'(32'(row_reg));
    assign res.dot_sum   = acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd_take && is_mac;
            s1_last_reg  <= (cmd_head.op == OP_MAC_LAST);
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            acc_reg      <= acc_next;
            row_reg      <= row_next;
        end
    end

endmodule

// ===== src/qmv_out_queue.sv =====
// qmv_out_queue: small result queue feeding the pop side.
// Depends on qmv_pkg.
module qmv_out_queue
    import qmv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_push,
    input  res_t                  res,
    input  logic                  pop,
    output logic                  empty,
    output res_t                  head,
    output logic [OUTQ_CNT_W-1:0] count
);

    res_t                  q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                  deq;

    assign empty = (count_reg == '0);
    assign head  = q_reg[rd_ptr_reg];
    assign count = count_reg;
    assign deq   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = res_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(res_push) - OUTQ_CNT_W'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== src/quantized_matrix_vector_multiply.sv =====
// quantized_matrix_vector_multiply: top level. Zero-point registers on an
// APB-style port, front classifier/queue, MAC back end, result queue.
// Depends on qmv_pkg, qmv_front, qmv_back, qmv_out_queue.
//
//   channel   handshake                    payload
//   -------   --------------------------   -------------------------------
//   input     push / full                  cmd, column, code
//   result    pop / empty                  row_index, dot_sum
//   config    psel penable pwrite pready   paddr, pwdata, prdata
//
// One item per cycle sustained while the result side keeps popping. In an idle
// block the closing weight item goes into the front queue on its accepting edge,
// then passes store read, multiply, and accumulate into the result queue in
// turn, after which empty goes low.
// The front queue holds four items, the result queue four results; the
// back end issues only when the result queue can absorb every row-closing
// item in flight, so a stalled pop side backs up into full.
// Reset clears queues, accumulator and row counter; the activation store is
// not cleared and holds garbage until loaded.
module quantized_matrix_vector_multiply
    import qmv_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input items
    input  logic                        push,
    output logic                        full,
    input  logic                        cmd,
    input  logic [COL_W-1:0]            column,
    input  logic [CODE_W-1:0]           code,
    // result items
    output logic                        empty,
    input  logic                        pop,
    output logic [ROW_IDX_W-1:0]        row_index,
    output logic signed [SUM_W-1:0]     dot_sum,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic [ZP_W-1:0]       act_zp_reg;
    logic [ZP_W-1:0]       wgt_zp_reg;
    logic                  cfg_wr;

    logic                  cmd_valid;
    cmd_t                  cmd_head;
    logic                  cmd_take;
    logic                  res_push;
    res_t                  res;
    res_t                  head;
    logic [OUTQ_CNT_W-1:0] outq_count;

    // ---- configuration registers: index is the word address bit ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_zp_reg <= '0;
            wgt_zp_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ACT_ZP:    act_zp_reg <= pwdata[ZP_W-1:0];
                REG_WEIGHT_ZP: wgt_zp_reg <= pwdata[ZP_W-1:0];
                default:       act_zp_reg <= act_zp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ACT_ZP:    prdata = APB_DATA_W'(act_zp_reg);
            REG_WEIGHT_ZP: prdata = APB_DATA_W'(wgt_zp_reg);
            default:       prdata = '0;
        endcase
    end

    // ---- front: accept, classify, queue ----
    qmv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .column    (column),
        .code      (code),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_take  (cmd_take)
    );

    // ---- back: store and MAC pipe ----
    qmv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_head   (cmd_head),
        .cmd_take   (cmd_take),
        .act_zp     (act_zp_reg),
        .wgt_zp     (wgt_zp_reg),
        .outq_count (outq_count),
        .res_push   (res_push),
        .res        (res)
    );

    // ---- result queue ----
    qmv_out_queue u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .pop      (pop),
        .empty    (empty),
        .head     (head),
        .count    (outq_count)
    );

    assign row_index = head.row_index;
    assign dot_sum   = head.dot_sum;

    // ---- checks ----
    // credit scheme must keep the result queue from overflowing
    a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && outq_count == OUTQ_CNT_W'(OUTQ_DEPTH) && !(pop && !empty)))
        else $error("result queue overflow");

    // back end never takes from an empty command queue
    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

    // a row-closing MAC produces a result once it has passed stages 1 and 2
    a_close_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd_head.op == OP_MAC_LAST) |=> ##1 res_push)
        else $error("row-closing item produced no result");

    // a result push comes only from a row-closing command
    a_push_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> $past(cmd_take && cmd_head.op == OP_MAC_LAST, 2))
        else $error("spurious result push");

endmodule

// ===== tb/sv/quantized_matrix_vector_multiply_tb.sv =====
// quantized_matrix_vector_multiply_tb: self-checking bench for the quantized
// matrix-vector multiply core. It predicts every row sum and checks it on the result side.
// Depends on qmv_pkg and the quantized_matrix_vector_multiply RTL.
module quantized_matrix_vector_multiply_tb;
    import qmv_pkg::*;

    // input item commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // register byte addresses, 4 bytes per register
    localparam logic [APB_ADDR_W-1:0] ADDR_ACT_ZP    = APB_ADDR_W'(4 * REG_ACT_ZP);
    localparam logic [APB_ADDR_W-1:0] ADDR_WEIGHT_ZP = APB_ADDR_W'(4 * REG_WEIGHT_ZP);

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 24;    // front queue + 3-stage MAC pipe, with margin
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 150;

    // ------------------------------------------------------------------
    // Row-sum predictor and result checker. It keeps its own copy of the
    // activation codes, the zero points, the running sum and the row count.
    // ------------------------------------------------------------------
    class row_sum_tracker;
        logic [ACT_W-1:0]        act_codes [VEC_LEN];
        logic signed [ZP_W-1:0]  act_zp;
        logic signed [ZP_W-1:0]  wt_zp;
        logic [SUM_W-1:0]        running_sum;
        logic [ROW_IDX_W-1:0]    row_ctr;
        res_t                    pending_rows [$];
        int                      fail_count;
        int                      rows_checked;

        function new();
            act_zp       = '0;
            wt_zp        = '0;
            running_sum  = '0;
            row_ctr      = '0;
            fail_count   = 0;
            rows_checked = 0;
        endfunction

        function void flag(string what);
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH @%0t: %s", $realtime, what);
        endfunction

        // accepted input item
        function void take_item(logic c, logic [COL_W-1:0] col, logic [CODE_W-1:0] cd);
            int   a;
            int   w;
            res_t r;
            if (col >= VEC_LEN)
                return;
            if (c == CMD_LOAD) begin
                act_codes[col] = {1'b0, cd};
                return;
            end
            a = int'(act_codes[col]) - int'(act_zp);
            w = int'(cd) - int'(wt_zp);
            running_sum = running_sum + SUM_W'(a * w);   // wraps, no saturation
            if (col != VEC_LEN - 1)
                return;
            r.row_index = row_ctr;
            r.dot_sum   = running_sum;
            pending_rows.push_back(r);
            running_sum = '0;
            row_ctr     = (row_ctr == ROW_IDX_W'(ROWS - 1)) ? '0 : row_ctr + 1'b1;
        endfunction

        // accepted result item
        function void check_row(logic [ROW_IDX_W-1:0] ri, logic signed [SUM_W-1:0] ds);
            res_t e;
            if (pending_rows.size() == 0) begin
                flag($sformatf("unexpected result row_index %0d dot_sum %0d", ri, ds));
                return;
            end
            e = pending_rows.pop_front();
            rows_checked++;
            if (e.row_index !== ri || e.dot_sum !== ds)
                flag($sformatf("expected row_index %0d dot_sum %0d, got row_index %0d dot_sum %0d",
                               e.row_index, e.dot_sum, ri, ds));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals, inputs all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                     clk     = 1'b0;
    logic                     rst_n   = 1'b0;
    logic                     push    = 1'b0;
    logic                     full;
    logic                     cmd     = CMD_LOAD;
    logic [COL_W-1:0]         column  = '0;
    logic [CODE_W-1:0]        code    = '0;
    logic                     empty;
    logic                     pop     = 1'b0;
    logic [ROW_IDX_W-1:0]     row_index;
    logic signed [SUM_W-1:0]  dot_sum;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr   = '0;
    logic [APB_DATA_W-1:0]    pwdata  = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    row_sum_tracker sums;
    bit             act_loaded [VEC_LEN];   // never weight a column not loaded since reset
    logic           steady = 1'b0;          // no idling on either side while set
    int             items_pushed = 0;
    int             settings_used = 0;
    int             pop_hold = 0;
    int             stall_cycles = 0;

    quantized_matrix_vector_multiply uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .column    (column),
        .code      (code),
        .empty     (empty),
        .pop       (pop),
        .row_index (row_index),
        .dot_sum   (dot_sum),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Input side. Every task is entered just after a rising edge; signals
    // are sampled there, so they hold their values from before the edge.
    // ------------------------------------------------------------------
    task automatic hold_input(input int n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Present one item, wait for push && !full, then maybe leave a gap.
    task automatic push_item(input logic c, input logic [COL_W-1:0] col,
                             input logic [CODE_W-1:0] cd);
        int roll;
        push   <= 1'b1;
        cmd    <= c;
        column <= col;
        code   <= cd;
        do
            @(posedge clk);
        while (full);
        sums.take_item(c, col, cd);
        items_pushed++;
        if (c == CMD_LOAD)
            act_loaded[col] = 1'b1;
        roll = $urandom_range(99);
        if (!steady && roll < 3)
            hold_input($urandom_range(5, 20));     // occasional long gap
        else if (!steady && roll < 25)
            hold_input(1);
    endtask

    // Codes lean toward both ends of the range.
    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    // Let the block go idle: all rows out, then the MAC pipe drained of
    // weights that close no row.
    task automatic settle();
        push <= 1'b0;
        while (sums.pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup cycle, access cycle, then idle.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [APB_ADDR_W-1:0] addr, input logic signed [ZP_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        read_reg(addr, got);
        if (got[ZP_W-1:0] !== want)
            sums.flag($sformatf("register at 0x%0h: expected %0d, read %0d",
                                addr, want, $signed(got[ZP_W-1:0])));
    endtask

    // Only called with the block idle. Writes both offsets and reads them back.
    task automatic set_zero_points(input logic signed [ZP_W-1:0] az, input logic signed [ZP_W-1:0] wz);
        write_reg(ADDR_ACT_ZP, {{(APB_DATA_W-ZP_W){az[ZP_W-1]}}, az});
        write_reg(ADDR_WEIGHT_ZP, {{(APB_DATA_W-ZP_W){wz[ZP_W-1]}}, wz});
        sums.act_zp = az;
        sums.wt_zp  = wz;
        check_reg(ADDR_ACT_ZP, az);
        check_reg(ADDR_WEIGHT_ZP, wz);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly weights on loaded columns, rows closed by
    // column VEC_LEN-1 after a random number of weights (repeats allowed),
    // activation reloads sprinkled in between.
    // ------------------------------------------------------------------
    task automatic random_stream(input int count);
        int               roll;
        logic [COL_W-1:0] col;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                push_item(CMD_LOAD, COL_W'($urandom), pick_code());
            end else begin
                col = (roll < 25) ? COL_W'(VEC_LEN - 1) : COL_W'($urandom);
                if (act_loaded[col])
                    push_item(CMD_WEIGHT, col, pick_code());
                else
                    push_item(CMD_LOAD, col, pick_code());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted result, then pick pop for the next
    // edge. Short random gaps plus rare long stalls that back up into full.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && pop && !empty)
            sums.check_row(row_index, dot_sum);
        if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else if (!steady && $urandom_range(99) < 2) begin
            pop_hold = $urandom_range(8, 30);
            pop <= 1'b0;
        end else begin
            pop <= steady || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog: ends the run if neither side moves for too long.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("quantized_matrix_vector_multiply_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic signed [ZP_W-1:0] az;
        logic signed [ZP_W-1:0] wz;
        sums = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // registers come out of reset as zero
        check_reg(ADDR_ACT_ZP, '0);
        check_reg(ADDR_WEIGHT_ZP, '0);

        // Directed, offsets at zero: code and column extremes, both commands,
        // a repeated column inside a row, a one-weight row, an overwritten code.
        set_zero_points(8'sh00, 8'sh00);
        push_item(CMD_LOAD, 0, 0);
        push_item(CMD_LOAD, 1, 127);
        push_item(CMD_LOAD, 62, 0);
        push_item(CMD_LOAD, 63, 127);
        push_item(CMD_WEIGHT, 0, 127);
        push_item(CMD_WEIGHT, 1, 0);
        push_item(CMD_WEIGHT, 1, 127);
        push_item(CMD_WEIGHT, 63, 127);     // closes row 0
        push_item(CMD_WEIGHT, 63, 0);       // row made of its closing weight only
        push_item(CMD_LOAD, 63, 0);
        push_item(CMD_WEIGHT, 63, 127);

        // Directed, offsets at the negative extreme: 255 * 255 products, so
        // the 16-bit sum wraps.
        settle();
        set_zero_points(8'sh80, 8'sh80);
        push_item(CMD_LOAD, 63, 127);
        push_item(CMD_WEIGHT, 63, 127);
        push_item(CMD_WEIGHT, 1, 127);
        push_item(CMD_WEIGHT, 62, 0);
        push_item(CMD_WEIGHT, 1, 127);
        push_item(CMD_WEIGHT, 63, 127);

        // Random phases, one offset setting each; extremes first.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin az = 8'sh80; wz = 8'sh80; end
                1:       begin az = 8'sh7F; wz = 8'sh7F; end
                2:       begin az = 8'sh80; wz = 8'sh7F; end
                3:       begin az = 8'sh7F; wz = 8'sh80; end
                4:       begin az = 8'sh00; wz = 8'sh00; end
                default: begin az = ZP_W'($urandom); wz = ZP_W'($urandom); end
            endcase
            settle();
            set_zero_points(az, wz);
            if (ph == 3)
                steady <= 1'b1;             // back-to-back stretch, both sides
            if (ph == 0) begin
                // full vector load, then one complete row in column order
                for (int c = 0; c < VEC_LEN; c++)
                    push_item(CMD_LOAD, COL_W'(c), pick_code());
                for (int c = 0; c < VEC_LEN; c++)
                    push_item(CMD_WEIGHT, COL_W'(c), pick_code());
            end
            random_stream(PHASE_ITEMS);
            if (ph == 3)
                steady <= 1'b0;
        end

        // drain, then watch a while longer for stray results
        push <= 1'b0;
        while (sums.pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d items pushed, %0d row sums checked, row counter wrapped %0d times",
                 items_pushed, sums.rows_checked, sums.rows_checked / ROWS);
        $display("summary: %0d offset settings incl. both extremes, %0d failures",
                 settings_used, sums.fail_count);
        if (sums.fail_count == 0 && sums.pending_rows.size() == 0)
            $display("quantized_matrix_vector_multiply_tb: done, clean");
        else
            $display("quantized_matrix_vector_multiply_tb: done, errors");
        $finish;
    end

endmodule
